FILE: design/aarm_pkg.sv
// Shared types and constants for the axis-angle rotation matrix block.
// Used by aarm_reduce, aarm_cordic_cell, aarm_matrix and the top level.
`default_nettype none

package aarm_pkg;

  localparam int CORDIC_STEPS_DEF  = 16;
  localparam int FRACTION_BITS_DEF = 14;
  localparam int ATAN_DEPTH        = 24;

  // Binary angle units: a full turn is 2^32.
  localparam logic signed [32:0] CORDIC_GAIN  = 33'sd652032874;
  localparam logic signed [32:0] QUARTER_TURN = 33'sd1073741824;
  localparam logic signed [32:0] HALF_TURN    = 33'sd2147483648;

  // Angle reduction: 23040 = 45 * 512 units of 1/64 degree.
  localparam logic [15:0] RECIP_45   = 16'd46604;   // ceil(2^21 / 45)
  localparam logic [15:0] TURN_BIAS  = 16'd16425;   // 45 * 365, keeps the turn count positive
  localparam logic [15:0] DIV_45     = 16'd45;
  localparam logic [31:0] FRAC_STEP  = 32'd186413;  // floor(2^23 / 45)

  localparam logic signed [32:0] ATAN_TABLE [ATAN_DEPTH] = '{
    33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
    33'sd42667331,  33'sd21354465,  33'sd10679838,  33'sd5340245,
    33'sd2670163,   33'sd1335087,   33'sd667544,    33'sd333772,
    33'sd166886,    33'sd83443,     33'sd41722,     33'sd20861,
    33'sd10430,     33'sd5215,      33'sd2608,      33'sd1304,
    33'sd652,       33'sd326,       33'sd163,       33'sd81
  };

  localparam int ENTRY_W   = 20;
  localparam int ENTRIES   = 9;
  localparam int IN_DATA_W = 72;
  localparam int OUT_DATA_W = 184;

  typedef struct packed {
    logic signed [15:0] z;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } axis_t;

  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [32:0] z;
    logic               neg;
    axis_t              axis;
  } rot_t;

  // Entry 0 is row 0 column 0, entry 8 is row 2 column 2.
  typedef logic [ENTRIES-1:0][ENTRY_W-1:0] mat_t;

endpackage

`default_nettype wire

FILE: design/aarm_reduce.sv
// Angle reduction front end: modulo 360 degrees, binary angle, quadrant fold.
// Depends on aarm_pkg. Five registered stages with per-stage flow control.
`default_nettype none

module aarm_reduce (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire aarm_pkg::axis_t    in_axis,
  input  wire logic signed [23:0] in_angle,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output aarm_pkg::rot_t          out_data
);

  localparam int STAGES = 5;

  logic [STAGES-1:0] valid_r;
  logic [STAGES:0]   adv;

  always_comb begin
    adv[STAGES] = out_ready;
    for (int k = STAGES - 1; k >= 0; k--) begin
      adv[k] = !valid_r[k] || adv[k+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = valid_r[STAGES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      for (int k = 0; k < STAGES; k++) begin
        if (adv[k]) begin
          valid_r[k] <= (k == 0) ? in_valid : valid_r[k-1];
        end
      end
    end
  end

  // Stage 1: turn count estimate, (angle / 512) divided by 45
  logic [15:0]         s1_w_r, s1_w_nxt;
  logic [9:0]          s1_q_r, s1_q_nxt;
  logic [8:0]          s1_low_r;
  aarm_pkg::axis_t     s1_axis_r;
  logic signed [16:0]  w_full;
  logic [31:0]         prod1;

  always_comb begin
    w_full   = {{2{in_angle[23]}}, in_angle[23:9]} + signed'({1'b0, aarm_pkg::TURN_BIAS});
    s1_w_nxt = w_full[15:0];
    prod1    = {16'b0, s1_w_nxt} * {16'b0, aarm_pkg::RECIP_45};
    s1_q_nxt = prod1[30:21];
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_w_r    <= s1_w_nxt;
      s1_q_r    <= s1_q_nxt;
      s1_low_r  <= in_angle[8:0];
      s1_axis_r <= in_axis;
    end
  end

  // Stage 2: remainder in [0, 23040)
  logic [14:0]     s2_v_r, s2_v_nxt;
  aarm_pkg::axis_t s2_axis_r;
  logic [15:0]     m_full;

  always_comb begin
    m_full   = s1_w_r - 16'(aarm_pkg::DIV_45 * {6'b0, s1_q_r});
    s2_v_nxt = {m_full[5:0], s1_low_r};
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s2_v_r    <= s2_v_nxt;
      s2_axis_r <= s1_axis_r;
    end
  end

  // Stage 3: whole 1/45 steps of the remainder
  logic [14:0]     s3_v_r;
  logic [8:0]      s3_a_r, s3_a_nxt;
  aarm_pkg::axis_t s3_axis_r;
  logic [31:0]     prod2;

  always_comb begin
    prod2    = {17'b0, s2_v_r} * {16'b0, aarm_pkg::RECIP_45};
    s3_a_nxt = prod2[29:21];
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s3_v_r    <= s2_v_r;
      s3_a_r    <= s3_a_nxt;
      s3_axis_r <= s2_axis_r;
    end
  end

  // Stage 4: leftover below 45
  logic [8:0]      s4_a_r;
  logic [5:0]      s4_b_r, s4_b_nxt;
  aarm_pkg::axis_t s4_axis_r;
  logic [14:0]     b_full;

  always_comb begin
    b_full   = s3_v_r - 15'(aarm_pkg::DIV_45 * {7'b0, s3_a_r});
    s4_b_nxt = b_full[5:0];
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s4_a_r    <= s3_a_r;
      s4_b_r    <= s4_b_nxt;
      s4_axis_r <= s3_axis_r;
    end
  end

  // Stage 5: binary angle, fold into [-90, 90] degrees, seed the rotation
  aarm_pkg::rot_t     s5_r, s5_nxt;
  logic [31:0]        t;
  logic signed [32:0] tz;

  always_comb begin
    // floor(b * 2^23 / 45) equals b * floor(2^23 / 45) + b / 2 for b below 45
    t  = {s4_a_r, 23'b0} + ({26'b0, s4_b_r} * aarm_pkg::FRAC_STEP)
         + {27'b0, s4_b_r[5:1]};
    tz = signed'({t[31], t});
    s5_nxt.x    = aarm_pkg::CORDIC_GAIN;
    s5_nxt.y    = '0;
    s5_nxt.axis = s4_axis_r;
    if (tz > aarm_pkg::QUARTER_TURN) begin
      s5_nxt.z   = tz - aarm_pkg::HALF_TURN;
      s5_nxt.neg = 1'b1;
    end else if (tz < -aarm_pkg::QUARTER_TURN) begin
      s5_nxt.z   = tz + aarm_pkg::HALF_TURN;
      s5_nxt.neg = 1'b1;
    end else begin
      s5_nxt.z   = tz;
      s5_nxt.neg = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s5_r <= s5_nxt;
    end
  end

  assign out_data = s5_r;

endmodule

`default_nettype wire

FILE: design/aarm_cordic_cell.sv
// One rotation-mode CORDIC step with its own output register and flow control.
// Depends on aarm_pkg for the rotation state type and the arctangent table.
`default_nettype none

module aarm_cordic_cell #(
  parameter int STEP = 0
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire aarm_pkg::rot_t  in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output aarm_pkg::rot_t       out_data
);

  logic               valid_r;
  aarm_pkg::rot_t     data_r, data_nxt;
  logic signed [32:0] dx, dy;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    dx       = in_data.y >>> STEP;
    dy       = in_data.x >>> STEP;
    data_nxt = in_data;
    if (!in_data.z[32]) begin
      data_nxt.x = in_data.x - dx;
      data_nxt.y = in_data.y + dy;
      data_nxt.z = in_data.z - aarm_pkg::ATAN_TABLE[STEP];
    end else begin
      data_nxt.x = in_data.x + dx;
      data_nxt.y = in_data.y - dy;
      data_nxt.z = in_data.z + aarm_pkg::ATAN_TABLE[STEP];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/aarm_matrix.sv
// Rodrigues matrix assembly: products, outer terms, sum, round and saturate.
// Depends on aarm_pkg. Three registered stages; the last is the output register.
`default_nettype none

module aarm_matrix #(
  parameter int FRACTION_BITS = aarm_pkg::FRACTION_BITS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire aarm_pkg::rot_t  in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output aarm_pkg::mat_t       out_data
);

  localparam int STAGES = 3;
  localparam int NN_XX = 0;
  localparam int NN_YY = 1;
  localparam int NN_ZZ = 2;
  localparam int NN_XY = 3;
  localparam int NN_XZ = 4;
  localparam int NN_YZ = 5;
  localparam int NN_CNT = 6;
  localparam logic signed [32:0] ONE     = 33'sd1073741824;
  localparam logic signed [63:0] HALF_LSB = 64'sd536870912;
  localparam logic signed [63:0] OUT_MAX  = 64'sd524287;
  localparam logic signed [63:0] OUT_MIN  = -64'sd524288;

  logic [STAGES-1:0] valid_r;
  logic [STAGES:0]   adv;

  always_comb begin
    adv[STAGES] = out_ready;
    for (int k = STAGES - 1; k >= 0; k--) begin
      adv[k] = !valid_r[k] || adv[k+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = valid_r[STAGES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      for (int k = 0; k < STAGES; k++) begin
        if (adv[k]) begin
          valid_r[k] <= (k == 0) ? in_valid : valid_r[k-1];
        end
      end
    end
  end

  // Stage 1: undo the fold, form 1 - c and the axis products
  logic signed [32:0] m1_c_r, m1_s_r, m1_omc_r;
  logic signed [32:0] m1_c_nxt, m1_s_nxt;
  logic signed [31:0] m1_nn_r [NN_CNT];
  logic signed [31:0] m1_nn_nxt [NN_CNT];
  aarm_pkg::axis_t    m1_axis_r;

  always_comb begin
    m1_c_nxt = in_data.neg ? -in_data.x : in_data.x;
    m1_s_nxt = in_data.neg ? -in_data.y : in_data.y;
    m1_nn_nxt[NN_XX] = in_data.axis.x * in_data.axis.x;
    m1_nn_nxt[NN_YY] = in_data.axis.y * in_data.axis.y;
    m1_nn_nxt[NN_ZZ] = in_data.axis.z * in_data.axis.z;
    m1_nn_nxt[NN_XY] = in_data.axis.x * in_data.axis.y;
    m1_nn_nxt[NN_XZ] = in_data.axis.x * in_data.axis.z;
    m1_nn_nxt[NN_YZ] = in_data.axis.y * in_data.axis.z;
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      m1_c_r    <= m1_c_nxt;
      m1_s_r    <= m1_s_nxt;
      m1_omc_r  <= ONE - m1_c_nxt;
      m1_nn_r   <= m1_nn_nxt;
      m1_axis_r <= in_data.axis;
    end
  end

  // Stage 2: outer terms, skew terms and the scaled diagonal
  logic signed [63:0] m2_outer_r [NN_CNT];
  logic signed [63:0] m2_outer_nxt [NN_CNT];
  logic signed [63:0] m2_sx_r, m2_sy_r, m2_sz_r, m2_cd_r;
  logic signed [48:0] sx, sy, sz;
  logic signed [64:0] prod [NN_CNT];
  logic signed [64:0] shifted [NN_CNT];
  logic signed [63:0] c_ext;

  always_comb begin
    for (int k = 0; k < NN_CNT; k++) begin
      prod[k]         = m1_omc_r * m1_nn_r[k];
      shifted[k]      = prod[k] >>> FRACTION_BITS;
      m2_outer_nxt[k] = shifted[k][63:0];
    end
    sx    = m1_s_r * m1_axis_r.x;
    sy    = m1_s_r * m1_axis_r.y;
    sz    = m1_s_r * m1_axis_r.z;
    c_ext = 64'(m1_c_r);
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      m2_outer_r <= m2_outer_nxt;
      m2_sx_r    <= 64'(sx);
      m2_sy_r    <= 64'(sy);
      m2_sz_r    <= 64'(sz);
      m2_cd_r    <= c_ext <<< FRACTION_BITS;
    end
  end

  // Stage 3: sum, round halves upward, saturate
  function automatic logic [aarm_pkg::ENTRY_W-1:0] round_sat(logic signed [63:0] acc);
    logic signed [63:0] r;
    r = (acc + HALF_LSB) >>> 30;
    if (r > OUT_MAX) begin
      r = OUT_MAX;
    end else if (r < OUT_MIN) begin
      r = OUT_MIN;
    end
    return r[aarm_pkg::ENTRY_W-1:0];
  endfunction

  aarm_pkg::mat_t m3_r, m3_nxt;

  always_comb begin
    m3_nxt[0] = round_sat(m2_cd_r + m2_outer_r[NN_XX]);
    m3_nxt[1] = round_sat(m2_outer_r[NN_XY] - m2_sz_r);
    m3_nxt[2] = round_sat(m2_outer_r[NN_XZ] + m2_sy_r);
    m3_nxt[3] = round_sat(m2_outer_r[NN_XY] + m2_sz_r);
    m3_nxt[4] = round_sat(m2_cd_r + m2_outer_r[NN_YY]);
    m3_nxt[5] = round_sat(m2_outer_r[NN_YZ] - m2_sx_r);
    m3_nxt[6] = round_sat(m2_outer_r[NN_XZ] - m2_sy_r);
    m3_nxt[7] = round_sat(m2_outer_r[NN_YZ] + m2_sx_r);
    m3_nxt[8] = round_sat(m2_cd_r + m2_outer_r[NN_ZZ]);
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      m3_r <= m3_nxt;
    end
  end

  assign out_data = m3_r;

endmodule

`default_nettype wire

FILE: design/axis_angle_rotation_matrix.sv
// Axis-angle rotation matrix, top level: reduce -> CORDIC cell chain -> matrix.
// Pipeline: 5 reduction stages, one cell per CORDIC step, 3 matrix stages.
// Throughput: one item per cycle unless out_tready stalls the output; every stage
// has its own valid bit, so bubbles close up under stall.
// Reset (rst_n low, synchronous) clears all valid bits; payload is not reset.
`default_nettype none

module axis_angle_rotation_matrix #(
  parameter int CORDIC_STEPS  = aarm_pkg::CORDIC_STEPS_DEF,
  parameter int FRACTION_BITS = aarm_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // axis_x [15:0], axis_y [31:16], axis_z [47:32], angle_degrees [71:48]
  input  wire logic [aarm_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // row0_col0 [19:0], row0_col1, row0_col2, row1_col0, row1_col1, row1_col2,
  // row2_col0, row2_col1, row2_col2 [179:160], zero [183:180]
  output logic [aarm_pkg::OUT_DATA_W-1:0]        out_tdata
);

  aarm_pkg::axis_t in_axis;
  logic signed [23:0] in_angle;

  assign in_axis.x = in_tdata[15:0];
  assign in_axis.y = in_tdata[31:16];
  assign in_axis.z = in_tdata[47:32];
  assign in_angle  = in_tdata[71:48];

  logic                stage_valid [CORDIC_STEPS+1];
  logic                stage_ready [CORDIC_STEPS+1];
  aarm_pkg::rot_t      stage_data  [CORDIC_STEPS+1];

  aarm_reduce u_reduce (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_axis   (in_axis),
    .in_angle  (in_angle),
    .out_valid (stage_valid[0]),
    .out_ready (stage_ready[0]),
    .out_data  (stage_data[0])
  );

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    aarm_cordic_cell #(
      .STEP (g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (stage_valid[g]),
      .in_ready  (stage_ready[g]),
      .in_data   (stage_data[g]),
      .out_valid (stage_valid[g+1]),
      .out_ready (stage_ready[g+1]),
      .out_data  (stage_data[g+1])
    );
  end

  aarm_pkg::mat_t mat;

  aarm_matrix #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_matrix (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (stage_valid[CORDIC_STEPS]),
    .in_ready  (stage_ready[CORDIC_STEPS]),
    .in_data   (stage_data[CORDIC_STEPS]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (mat)
  );

  assign out_tdata = {4'b0, mat};

endmodule

`default_nettype wire

FILE: verif/tb_axis_angle_rotation_matrix.sv
// Self-checking testbench for axis_angle_rotation_matrix: drives axis/angle items;
// checks each against a bit-accurate Rodrigues/CORDIC predictor or a fixed diagonal.
// Depends on aarm_pkg and the RTL of the block; reads no files.

module tb_axis_angle_rotation_matrix;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CORDIC_STEPS  = 16;
  localparam int FRACTION_BITS = 14;
  localparam int LATENCY       = CORDIC_STEPS + 8;
  localparam int STALL_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 150;
  localparam int PHASE_ITEMS   = 200;
  localparam longint ENT_MAX   = 524287;
  localparam longint ENT_MIN   = -524288;

  localparam longint TURN_64THS = 23040;
  localparam longint UNIT_Q30   = 64'sd1 <<< 30;
  localparam longint K_GAIN     = 64'sd652032874;
  localparam longint ARCTAN [24] = '{
    64'sd536870912, 64'sd316933406, 64'sd167458907, 64'sd85004756,
    64'sd42667331,  64'sd21354465,  64'sd10679838,  64'sd5340245,
    64'sd2670163,   64'sd1335087,   64'sd667544,    64'sd333772,
    64'sd166886,    64'sd83443,     64'sd41722,     64'sd20861,
    64'sd10430,     64'sd5215,      64'sd2608,      64'sd1304,
    64'sd652,       64'sd326,       64'sd163,       64'sd81
  };

  // Rows with fixed_exp set have a zero axis, so the matrix is fixed_diag * I.
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic signed [23:0] angle;
    logic               fixed_exp;
    logic signed [19:0] fixed_diag;
  } dir_row_t;

  localparam int NUM_DIR = 22;
  localparam dir_row_t DIR_TAB [NUM_DIR] = '{
    '{16'sd0, 16'sd0, 16'sd0, 24'sd0, 1'b1, 20'sd16384},
    '{16'sd0, 16'sd0, 16'sd0, 24'sd5760, 1'b1, 20'sd0},
    '{16'sd0, 16'sd0, 16'sd0, 24'sd11520, 1'b1, -20'sd16384},
    '{16'sd0, 16'sd0, 16'sd0, -24'sd5760, 1'b1, 20'sd0},
    '{16'sd0, 16'sd0, 16'sd0, 24'sd23040, 1'b1, 20'sd16384},
    '{16'sd0, 16'sd0, 16'sd0, 24'sd17280, 1'b1, 20'sd0},
    '{16'sd0, 16'sd0, 16'sd0, -24'sd69120, 1'b1, 20'sd16384},
    '{16'sd16384, 16'sd0, 16'sd0, 24'sd2880, 1'b0, 20'sd0},
    '{16'sd0, 16'sd16384, 16'sd0, 24'sd5761, 1'b0, 20'sd0},
    '{16'sd0, 16'sd0, 16'sd16384, -24'sd5761, 1'b0, 20'sd0},
    '{16'sd32767, 16'sd32767, 16'sd32767, 24'sd8388607, 1'b0, 20'sd0},
    '{-16'sd32768, -16'sd32768, -16'sd32768, -24'sd8388608, 1'b0, 20'sd0},
    '{16'sd32767, -16'sd32768, 16'sd0, 24'sd11520, 1'b0, 20'sd0},
    '{-16'sd32768, 16'sd32767, -16'sd32768, 24'sd8640, 1'b0, 20'sd0},
    '{16'sd9459, 16'sd9459, 16'sd9459, 24'sd7680, 1'b0, 20'sd0},
    '{16'sd0, 16'sd0, 16'sd0, 24'sd1, 1'b0, 20'sd0},
    '{16'sd11585, 16'sd11585, 16'sd0, -24'sd1, 1'b0, 20'sd0},
    '{16'sd1, -16'sd1, 16'sd1, 24'sd23039, 1'b0, 20'sd0},
    '{-16'sd1, 16'sd0, 16'sd0, 24'sd14400, 1'b0, 20'sd0},
    '{16'sd0, -16'sd32768, 16'sd32767, 24'sd20160, 1'b0, 20'sd0},
    '{16'sd16384, 16'sd16384, 16'sd16384, 24'sd11519, 1'b0, 20'sd0},
    '{16'sd32767, 16'sd0, 16'sd0, -24'sd11520, 1'b0, 20'sd0}
  };

  logic clk;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic [aarm_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic in_tready;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [aarm_pkg::OUT_DATA_W-1:0] out_tdata;

  aarm_pkg::mat_t pending_mats [$];
  int mismatches = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 9;
  int recv_idle_pct = 51;
  bit hold_req = 1'b0;
  int hold_left = 0;
  string entry_names [9] = '{"row0_col0", "row0_col1", "row0_col2", "row1_col0",
                             "row1_col1", "row1_col2", "row2_col0", "row2_col1",
                             "row2_col2"};

  axis_angle_rotation_matrix #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .FRACTION_BITS(FRACTION_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Reduce the angle to a binary angle, fold into +-90 degrees, run the CORDIC.
  function automatic void cordic_sin_cos(input logic signed [23:0] angle,
                                         output longint cos_v, output longint sin_v);
    longint r, t, x, y, z, dx, dy;
    bit flip;
    flip = 1'b0;
    r = longint'(angle) % TURN_64THS;
    if (r < 0) r += TURN_64THS;
    t = (r << 32) / TURN_64THS;
    if (t >= (64'sd1 <<< 31)) t -= (64'sd1 <<< 32);
    if (t > UNIT_Q30) begin
      t -= 2 * UNIT_Q30;
      flip = 1'b1;
    end else if (t < -UNIT_Q30) begin
      t += 2 * UNIT_Q30;
      flip = 1'b1;
    end
    x = K_GAIN;
    y = 0;
    z = t;
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= ARCTAN[i];
      end else begin
        x += dx;
        y -= dy;
        z += ARCTAN[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    cos_v = x;
    sin_v = y;
  endfunction

  function automatic aarm_pkg::mat_t rodrigues_matrix(input logic signed [15:0] ax,
                                                      input logic signed [15:0] ay,
                                                      input logic signed [15:0] az,
                                                      input logic signed [23:0] angle);
    longint c, s, one_minus_c, acc;
    longint n [3];
    longint skew [3][3];
    aarm_pkg::mat_t m;
    cordic_sin_cos(angle, c, s);
    n[0] = longint'(ax);
    n[1] = longint'(ay);
    n[2] = longint'(az);
    one_minus_c = UNIT_Q30 - c;
    skew[0][0] = 0;     skew[0][1] = -n[2]; skew[0][2] = n[1];
    skew[1][0] = n[2];  skew[1][1] = 0;     skew[1][2] = -n[0];
    skew[2][0] = -n[1]; skew[2][1] = n[0];  skew[2][2] = 0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        acc = (i == j) ? (c <<< FRACTION_BITS) : 64'sd0;
        acc += (one_minus_c * (n[i] * n[j])) >>> FRACTION_BITS;
        acc += s * skew[i][j];
        // round half up to the output fraction
        acc = (acc + (UNIT_Q30 >>> 1)) >>> 30;
        if (acc > ENT_MAX) acc = ENT_MAX;
        if (acc < ENT_MIN) acc = ENT_MIN;
        m[i * 3 + j] = acc[19:0];
      end
    end
    return m;
  endfunction

  function automatic logic signed [15:0] axis_corner();
    case ($urandom_range(4))
      0: return -16'sd32768;
      1: return -16'sd1;
      2: return 16'sd0;
      3: return 16'sd1;
      default: return 16'sd32767;
    endcase
  endfunction

  // Offer one item after a random gap; queue its matrix once it is taken.
  task automatic send_rotation(input logic signed [15:0] ax, input logic signed [15:0] ay,
                               input logic signed [15:0] az,
                               input logic signed [23:0] angle,
                               input aarm_pkg::mat_t want);
    int gap;
    gap = 0;
    while (gap < 8 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {angle, az, ay, ax};
    do @(posedge clk); while (!in_tready);
    pending_mats.push_back(want);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_mats.size() != 0) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    aarm_pkg::mat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_mats.size() == 0) begin
        $display("%0t: matrix item with none expected: %h", $time, out_tdata);
        mismatches++;
      end else begin
        want = pending_mats.pop_front();
        for (int k = 0; k < 9; k++) begin
          if (out_tdata[k * 20 +: 20] !== want[k]) begin
            $display("%0t: %s expected %0d, got %0d", $time, entry_names[k],
                     $signed(want[k]), $signed(out_tdata[k * 20 +: 20]));
            mismatches++;
          end
        end
        if (out_tdata[183:180] !== 4'b0000) begin
          $display("%0t: pad bits expected 0, got %b", $time, out_tdata[183:180]);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    aarm_pkg::mat_t want;
    logic signed [15:0] ax, ay, az;
    logic signed [23:0] angle;
    int pick;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_DIR; i++) begin
      if (DIR_TAB[i].fixed_exp) begin
        want = '0;
        want[0] = DIR_TAB[i].fixed_diag;
        want[4] = DIR_TAB[i].fixed_diag;
        want[8] = DIR_TAB[i].fixed_diag;
      end else begin
        want = rodrigues_matrix(DIR_TAB[i].x, DIR_TAB[i].y, DIR_TAB[i].z, DIR_TAB[i].angle);
      end
      send_rotation(DIR_TAB[i].x, DIR_TAB[i].y, DIR_TAB[i].z, DIR_TAB[i].angle, want);
    end

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 51 : 0;
      recv_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 9 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // stall the output long enough to back the pipe up into the input
        if (n == 60 && phase != 1) hold_req = 1'b1;
        if (n == 150) wait_drained();
        pick = $urandom_range(99);
        if (pick < 50) begin
          ax = 16'($urandom);
          ay = 16'($urandom);
          az = 16'($urandom);
          angle = 24'($urandom);
        end else if (pick < 70) begin
          // axis components in [-16384, 16384] at angles close to the quadrant edges
          ax = 16'($urandom_range(32768) - 16384);
          ay = 16'($urandom_range(32768) - 16384);
          az = 16'($urandom_range(32768) - 16384);
          angle = 24'((int'($urandom_range(15)) - 8) * 5760 + int'($urandom_range(8)) - 4);
        end else if (pick < 85) begin
          ax = axis_corner();
          ay = axis_corner();
          az = axis_corner();
          angle = 24'($urandom);
        end else begin
          ax = 16'($urandom);
          ay = 16'($urandom);
          az = 16'($urandom);
          angle = 24'(int'($urandom_range(92160)) - 46080);
        end
        send_rotation(ax, ay, az, angle, rodrigues_matrix(ax, ay, az, angle));
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_mats.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    if (mismatches == 0 && pending_mats.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/aarm_pkg.sv
design/aarm_reduce.sv
design/aarm_cordic_cell.sv
design/aarm_matrix.sv
design/axis_angle_rotation_matrix.sv
verif/tb_axis_angle_rotation_matrix.sv
